// ----- rtl/core/byte_stuffed_frame_deframer_top_assert.svh -----
// assertion macros for the byte-stuffed frame deframer
// used by the port checker; needs a clk and rst in the including scope
`ifndef BYTE_STUFFED_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define BYTE_STUFFED_FRAME_DEFRAMER_TOP_ASSERT_SVH

// implication checked on every rising edge outside reset
`define BSFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that only applies while a result is on offer
`define BSFD_ASSERT_OUT(label, prop, msg) \
  `BSFD_ASSERT(label, out_valid |-> (prop), msg)

`endif

// ----- rtl/core/bsfd_pkg.sv -----
// shared constants, types and helpers for the byte-stuffed frame deframer
// no dependencies
package bsfd_pkg;

  // width of the stored length limit
  localparam int LEN_BITS = 16;
  localparam int CNT_BITS = 17;
  localparam logic [31:0] LIMIT_CAP = (32'd1 << LEN_BITS) - 32'd1;
  localparam logic [15:0] LIMIT_RESET = 16'd256;

  // line bytes
  localparam logic [7:0] FLAG_START = 8'h7E;
  localparam logic [7:0] FLAG_END   = 8'h8E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_START  = 8'h5E;
  localparam logic [7:0] ESC_ESC    = 8'h5D;
  localparam logic [7:0] ESC_END    = 8'h6E;

  // receive modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_ESC   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  // outcome of one byte: next state and the optional result
  typedef struct packed {
    logic [1:0]          mode_next;
    logic [CNT_BITS-1:0] count_next;
    logic                res_valid;
    logic [7:0]          res_byte;
    logic [1:0]          res_kind;
    logic [CNT_BITS-1:0] res_len;
  } step_t;

  // clamp a written limit to what the limit register can hold
  function automatic logic [LEN_BITS-1:0] sat_limit(input logic [15:0] value);
    logic [31:0] wide;
    wide = {16'd0, value};
    if (wide > LIMIT_CAP) begin
      sat_limit = LIMIT_CAP[LEN_BITS-1:0];
    end else begin
      sat_limit = wide[LEN_BITS-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/bsfd_step.sv -----
// per-byte decode of the deframer: mode and length update plus result
// depends on bsfd_pkg
module bsfd_step
  import bsfd_pkg::*;
(
  input  logic [1:0]          mode,
  input  logic [CNT_BITS-1:0] count,
  input  logic [LEN_BITS-1:0] limit,
  input  logic [7:0]          rx_byte,
  output step_t               step
);

  logic [31:0]         count_ext;
  logic [31:0]         limit_ext;
  logic                at_limit;
  logic [CNT_BITS-1:0] count_inc;
  logic                esc_ok;
  logic [7:0]          esc_val;
  step_t               ab;

  // length bookkeeping
  assign count_ext = {{(32-CNT_BITS){1'b0}}, count};
  assign limit_ext = {{(32-LEN_BITS){1'b0}}, limit};
  assign at_limit  = count_ext >= limit_ext;
  assign count_inc = count + {{(CNT_BITS-1){1'b0}}, 1'b1};

  // escape code restore
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = 8'd0;
    case (rx_byte)
      ESC_START: esc_val = FLAG_START;
      ESC_ESC:   esc_val = ESC_BYTE;
      ESC_END:   esc_val = FLAG_END;
      default:   esc_ok  = 1'b0;
    endcase
  end

  // abort, with the byte reconsidered as if idle
  always_comb begin
    ab.res_valid = 1'b1;
    if (rx_byte == FLAG_START) begin
      ab.mode_next  = MODE_FRAME;
      ab.count_next = {{(CNT_BITS-1){1'b0}}, 1'b1};
      ab.res_byte   = FLAG_START;
      ab.res_kind   = KIND_START;
      ab.res_len    = {{(CNT_BITS-1){1'b0}}, 1'b1};
    end else begin
      ab.mode_next  = MODE_IDLE;
      ab.count_next = '0;
      ab.res_byte   = 8'd0;
      ab.res_kind   = KIND_ABORT;
      ab.res_len    = count;
    end
  end

  // main mode decode
  always_comb begin
    step.mode_next  = mode;
    step.count_next = count;
    step.res_valid  = 1'b0;
    step.res_byte   = 8'd0;
    step.res_kind   = KIND_DATA;
    step.res_len    = count;
    case (mode)
      MODE_FRAME: begin
        if (rx_byte == ESC_BYTE) begin
          step.mode_next = MODE_ESC;
        end else if (rx_byte == FLAG_END) begin
          step.mode_next  = MODE_IDLE;
          step.count_next = count_inc;
          step.res_valid  = 1'b1;
          step.res_byte   = FLAG_END;
          step.res_kind   = KIND_END;
          step.res_len    = count_inc;
        end else if (rx_byte == FLAG_START) begin
          step.count_next = {{(CNT_BITS-1){1'b0}}, 1'b1};
          step.res_valid  = 1'b1;
          step.res_byte   = FLAG_START;
          step.res_kind   = KIND_START;
          step.res_len    = {{(CNT_BITS-1){1'b0}}, 1'b1};
        end else if (at_limit) begin
          step = ab;
        end else begin
          step.count_next = count_inc;
          step.res_valid  = 1'b1;
          step.res_byte   = rx_byte;
          step.res_kind   = KIND_DATA;
          step.res_len    = count_inc;
        end
      end
      MODE_ESC: begin
        if (at_limit || !esc_ok) begin
          step = ab;
        end else begin
          step.mode_next  = MODE_FRAME;
          step.count_next = count_inc;
          step.res_valid  = 1'b1;
          step.res_byte   = esc_val;
          step.res_kind   = KIND_DATA;
          step.res_len    = count_inc;
        end
      end
      default: begin
        // idle and the unused code wait for a start flag
        step.mode_next = MODE_IDLE;
        if (rx_byte == FLAG_START) begin
          step.mode_next  = MODE_FRAME;
          step.count_next = {{(CNT_BITS-1){1'b0}}, 1'b1};
          step.res_valid  = 1'b1;
          step.res_byte   = FLAG_START;
          step.res_kind   = KIND_START;
          step.res_len    = {{(CNT_BITS-1){1'b0}}, 1'b1};
        end
      end
    endcase
  end

endmodule

// ----- rtl/core/byte_stuffed_frame_deframer_top.sv -----
// A byte is held in the input register, and its result is offered from the result register.
// Throughput: one byte per cycle while the result is not stalled, set by the mode and length
// update in bsfd_step that each byte needs from the one before it.
// Reset (synchronous, rst high): idle mode, length 0, limit 256, both
// pipeline registers empty. Configuration writes are always taken.
// depends on bsfd_pkg and bsfd_step
module byte_stuffed_frame_deframer_top
  import bsfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [1:0]          kind,
  output logic [CNT_BITS-1:0] frame_len,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic                byte_valid;
  logic [7:0]          byte_reg;
  logic                proc_fire;
  logic [1:0]          rx_mode;
  logic [CNT_BITS-1:0] stored_count;
  logic [LEN_BITS-1:0] max_frame_len;
  step_t               step;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= sat_limit(LIMIT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      max_frame_len <= sat_limit(cfg_data);
    end
  end

  // the held byte moves on when the result register is free
  assign proc_fire = byte_valid && (!out_valid || out_ready);
  assign in_ready  = !byte_valid || proc_fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= rx_byte;
    end
  end

  // decode of the held byte
  bsfd_step u_step (
    .mode    (rx_mode),
    .count   (stored_count),
    .limit   (max_frame_len),
    .rx_byte (byte_reg),
    .step    (step)
  );

  // receive state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode      <= MODE_IDLE;
      stored_count <= '0;
    end else if (proc_fire) begin
      rx_mode      <= step.mode_next;
      stored_count <= step.count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= step.res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && step.res_valid) begin
      out_byte  <= step.res_byte;
      kind      <= step.res_kind;
      frame_len <= step.res_len;
    end
  end

endmodule

// ----- rtl/core/bsfd_checker.sv -----
// port-level checks on the deframer top, attached by bind
// depends on bsfd_pkg and byte_stuffed_frame_deframer_top_assert.svh
`include "byte_stuffed_frame_deframer_top_assert.svh"

module bsfd_checker
  import bsfd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [7:0]          rx_byte,
  input logic                out_valid,
  input logic                out_ready,
  input logic [7:0]          out_byte,
  input logic [1:0]          kind,
  input logic [CNT_BITS-1:0] frame_len,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [15:0]         cfg_data
);

  // a stalled result holds
  `BSFD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind) && $stable(frame_len), "stalled result changed")

  // a start always reports the flag and a length of one
  `BSFD_ASSERT_OUT(a_start_fmt, kind != KIND_START || (out_byte == FLAG_START && frame_len == 1), "bad start result")

  // an end carries the end flag and at least both flags
  `BSFD_ASSERT_OUT(a_end_fmt, kind != KIND_END || (out_byte == FLAG_END && frame_len >= 2), "bad end result")

  // data always extends a frame that is already open
  `BSFD_ASSERT_OUT(a_data_len, kind != KIND_DATA || frame_len >= 2, "data with short length")

  // an abort carries a zero byte and the discarded length
  `BSFD_ASSERT_OUT(a_abort_fmt, kind != KIND_ABORT || (out_byte == 8'd0 && frame_len != 0), "bad abort result")

endmodule

bind byte_stuffed_frame_deframer_top bsfd_checker u_bsfd_checker (.*);
